// ----- sv/assert_macros.svh -----
// Assertion macros used by the scaler back end.
// Needs a clock named clk and a reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked outside reset
`define CHK_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication
`define CHK_IMPL(label, ante, cons, msg) \
  `CHK_PROP(label, (ante) |-> (cons), msg)

// Next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
  `CHK_PROP(label, (ante) |=> (cons), msg)

`endif

// ----- sv/bis_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the bilinear image scaler.
// No dependencies.
package bis_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_WEIGHT_FRACTION_BITS = 16;

  localparam int POS_W   = 28;
  localparam int COORD_W = 12;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 3;

  // Entry fields sized for the widest parameter values
  localparam int ENT_ADDR_W = 24;
  localparam int ENT_X_W    = 12;
  localparam int ENT_WF_W   = 24;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_STEP  = 3'd4;

  typedef struct packed {
    logic                  emit;
    logic [23:0]           rgb;
    logic [ENT_ADDR_W-1:0] base_top;
    logic [ENT_ADDR_W-1:0] base_bottom;
    logic [ENT_X_W-1:0]    x_left;
    logic                  x_step;
    logic [ENT_WF_W-1:0]   dx;
    logic [ENT_WF_W-1:0]   dy;
    logic [COORD_W-1:0]    column;
    logic [COORD_W-1:0]    line;
    logic                  row_end;
    logic                  frame_end;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_PUSH
  } back_state_t;

endpackage

// ----- sv/bis_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration registers, request classification, raster counters.
// Depends on bis_pkg.
module bis_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int WEIGHT_FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  output logic                           q_push,
  input  logic                           q_ready,
  output bis_pkg::entry_t                q_entry
);
  import bis_pkg::*;

  localparam int WF   = WEIGHT_FRACTION_BITS;
  localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int SW_W = $clog2(MAX_WIDTH + 1);
  localparam int SH_W = $clog2(MAX_HEIGHT + 1);
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);

  logic [8:0]         source_width, source_height;
  logic [11:0]        output_width, output_height;
  logic [23:0]        inverse_step;
  logic [AW-1:0]      load_pointer;
  logic [COORD_W-1:0] emit_column, emit_row;
  logic [POS_W-1:0]   xpos, ypos;

  logic [SW_W-1:0]    sw;
  logic [SH_W-1:0]    sh;
  logic [11:0]        ow, oh;
  logic [AW:0]        frame_size, lp_inc;
  logic [11:0]        x_int, y_int;
  logic [XW-1:0]      x_left;
  logic [YW-1:0]      y_top;
  logic               x_step, y_step;
  logic [AW-1:0]      base_top, base_bottom;
  logic [WF+15:0]     dx_ext, dy_ext;
  logic               row_end, frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 9'd256;
      source_height <= 9'd256;
      output_width  <= 12'd256;
      output_height <= 12'd256;
      inverse_step  <= 24'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[8:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[8:0];
        REG_OUTPUT_WIDTH:  output_width  <= cfg_data[11:0];
        REG_OUTPUT_HEIGHT: output_height <= cfg_data[11:0];
        REG_INVERSE_STEP:  inverse_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (source_width == '0) sw = SW_W'(1);
    else if (32'(source_width) > MAX_WIDTH) sw = SW_W'(MAX_WIDTH);
    else sw = SW_W'(source_width);
    if (source_height == '0) sh = SH_W'(1);
    else if (32'(source_height) > MAX_HEIGHT) sh = SH_W'(MAX_HEIGHT);
    else sh = SH_W'(source_height);
    ow = (output_width == '0) ? 12'd1 : output_width;
    oh = (output_height == '0) ? 12'd1 : output_height;
  end

  assign frame_size = (AW+1)'(32'(sw) * 32'(sh));
  assign lp_inc     = (AW+1)'(load_pointer) + (AW+1)'(1);

  always_comb begin
    x_int = xpos[POS_W-1:16];
    y_int = ypos[POS_W-1:16];
    if (32'(x_int) >= 32'(sw) - 1) x_left = XW'(32'(sw) - 1);
    else x_left = XW'(x_int);
    if (32'(y_int) >= 32'(sh) - 1) y_top = YW'(32'(sh) - 1);
    else y_top = YW'(y_int);
    x_step = 32'(x_left) != 32'(sw) - 1;
    y_step = 32'(y_top) != 32'(sh) - 1;
  end

  assign base_top    = AW'(32'(y_top) * 32'(sw));
  assign base_bottom = y_step ? base_top + AW'(sw) : base_top;
  assign dx_ext      = (WF+16)'(xpos[15:0]) << WF;
  assign dy_ext      = (WF+16)'(ypos[15:0]) << WF;
  assign row_end     = emit_column >= ow - 12'd1;
  assign frame_end   = row_end && (emit_row >= oh - 12'd1);

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  always_comb begin
    q_entry             = '0;
    q_entry.emit        = command;
    q_entry.rgb         = {in_red, in_green, in_blue};
    q_entry.base_top    = ENT_ADDR_W'(command == CMD_EMIT ? base_top : load_pointer);
    q_entry.base_bottom = ENT_ADDR_W'(base_bottom);
    q_entry.x_left      = ENT_X_W'(x_left);
    q_entry.x_step      = x_step;
    q_entry.dx          = ENT_WF_W'(dx_ext[WF+15:16]);
    q_entry.dy          = ENT_WF_W'(dy_ext[WF+15:16]);
    q_entry.column      = emit_column;
    q_entry.line        = emit_row;
    q_entry.row_end     = row_end;
    q_entry.frame_end   = frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer <= '0;
      emit_column  <= '0;
      emit_row     <= '0;
      xpos         <= '0;
      ypos         <= '0;
    end else if (q_push) begin
      if (command == CMD_LOAD) begin
        load_pointer <= (lp_inc >= frame_size) ? '0 : lp_inc[AW-1:0];
      end else if (!row_end) begin
        emit_column <= emit_column + 12'd1;
        xpos        <= xpos + POS_W'(inverse_step);
      end else begin
        emit_column <= '0;
        xpos        <= '0;
        if (frame_end) begin
          emit_row <= '0;
          ypos     <= '0;
        end else begin
          emit_row <= emit_row + 12'd1;
          ypos     <= ypos + POS_W'(inverse_step);
        end
      end
    end
  end

endmodule

// ----- sv/bis_queue.sv -----
`timescale 1ns / 1ps
// Four-entry request queue between front and back ends.
// Depends on bis_pkg.
module bis_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            push_ready,
  input  bis_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  logic            pop,
  output bis_pkg::entry_t pop_entry
);
  import bis_pkg::*;

  entry_t     slots [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign push_ready = count != 3'd4;
  assign pop_valid  = count != 3'd0;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

// ----- sv/bis_back.sv -----
`timescale 1ns / 1ps
// Back end: frame store, four-neighbour read sequencer and weighted sum.
// Depends on bis_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bis_back #(
  parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
  parameter int WEIGHT_FRACTION_BITS = bis_pkg::DEF_WEIGHT_FRACTION_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  bis_pkg::entry_t              q_entry,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic [bis_pkg::COORD_W-1:0]  out_column,
  output logic [bis_pkg::COORD_W-1:0]  out_line,
  output logic                         row_end,
  output logic                         frame_end
);
  import bis_pkg::*;

  localparam int WF    = WEIGHT_FRACTION_BITS;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = 2 * WF + 1;
  localparam int ACC_W = 2 * WF + 8;

  back_state_t state, state_next;
  entry_t      ent;
  logic [23:0] frame_store [DEPTH];
  logic [23:0] mem_q;
  logic [WW-1:0]    w [4];
  logic [ACC_W-1:0] acc [3];
  logic [1:0]  k, rd_k;
  logic        rd_valid;
  logic        mem_we, mem_re, latch, push_out;
  logic [AW-1:0] rd_addr;
  logic [WF:0] one_w, dx, dy, ndx, ndy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (q_valid && q_entry.emit == CMD_EMIT) state_next = S_READ;
      S_READ:  if (k == 2'd3) state_next = S_DRAIN;
      S_DRAIN: state_next = S_PUSH;
      S_PUSH:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    latch    = 1'b0;
    push_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        q_pop  = q_valid;
        mem_we = q_valid && q_entry.emit == CMD_LOAD;
        latch  = q_valid && q_entry.emit == CMD_EMIT;
      end
      S_READ:  mem_re = 1'b1;
      S_DRAIN: ;
      S_PUSH:  push_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    one_w = {1'b1, {WF{1'b0}}};
    dx    = (WF+1)'(q_entry.dx[WF-1:0]);
    dy    = (WF+1)'(q_entry.dy[WF-1:0]);
    ndx   = one_w - dx;
    ndy   = one_w - dy;
  end

  always_comb begin
    rd_addr = (k[1] ? AW'(ent.base_bottom) : AW'(ent.base_top)) + AW'(ent.x_left);
    if (k[0] && ent.x_step) rd_addr = rd_addr + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (mem_we) frame_store[AW'(q_entry.base_top)] <= q_entry.rgb;
    if (mem_re) mem_q <= frame_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      ent  <= q_entry;
      w[0] <= WW'(ndx * ndy);
      w[1] <= WW'(dx * ndy);
      w[2] <= WW'(ndx * dy);
      w[3] <= WW'(dx * dy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      rd_k     <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= mem_re;
      rd_k     <= k;
      if (latch) k <= '0;
      else if (mem_re) k <= k + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      acc[0] <= '0;
      acc[1] <= '0;
      acc[2] <= '0;
    end else if (rd_valid) begin
      acc[0] <= acc[0] + ACC_W'(w[rd_k]) * ACC_W'(mem_q[23:16]);
      acc[1] <= acc[1] + ACC_W'(w[rd_k]) * ACC_W'(mem_q[15:8]);
      acc[2] <= acc[2] + ACC_W'(w[rd_k]) * ACC_W'(mem_q[7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (push_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (push_out) begin
      out_red    <= acc[0][ACC_W-1:2*WF];
      out_green  <= acc[1][ACC_W-1:2*WF];
      out_blue   <= acc[2][ACC_W-1:2*WF];
      out_column <= ent.column;
      out_line   <= ent.line;
      row_end    <= ent.row_end;
      frame_end  <= ent.frame_end;
    end
  end

  `CHK_IMPL(a_weight_sum, state == S_READ,
    (ACC_W'(w[0]) + ACC_W'(w[1]) + ACC_W'(w[2]) + ACC_W'(w[3])) == (ACC_W'(1) << (2 * WF)),
    "weights do not sum to one")
  `CHK_IMPL(a_frame_end_row, out_valid && frame_end, row_end, "frame end without row end")
  `CHK_IMPL(a_read_order, state == S_DRAIN, rd_k == 2'd3, "neighbour reads out of order")

endmodule

// ----- sv/bilinear_image_scaler.sv -----
`timescale 1ns / 1ps
// Bilinear RGB888 scaler. The back end stores a load request as it pops it. For an emit
// request, S_IDLE pops it and forms weights, S_READ makes four reads of the single-port
// frame store for the neighbours, S_DRAIN finishes the sum and S_PUSH hands the pixel to
// the output register once free. The front end and a four-entry queue take requests every
// cycle while the queue has room. The frame store has no reset; read only loaded pixels.
// Depends on bis_pkg, bis_front, bis_queue, bis_back.
module bilinear_image_scaler #(
  parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
  parameter int WEIGHT_FRACTION_BITS = bis_pkg::DEF_WEIGHT_FRACTION_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bis_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic [bis_pkg::COORD_W-1:0]   out_column,
  output logic [bis_pkg::COORD_W-1:0]   out_line,
  output logic                          row_end,
  output logic                          frame_end
);
  import bis_pkg::*;

  logic   push, push_ready, pop, pop_valid;
  entry_t push_entry, pop_entry;

  bis_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .WEIGHT_FRACTION_BITS(WEIGHT_FRACTION_BITS)
  ) u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .command, .in_red, .in_green, .in_blue,
    .q_push(push), .q_ready(push_ready), .q_entry(push_entry)
  );

  bis_queue u_queue (
    .clk, .rst, .push, .push_ready, .push_entry,
    .pop_valid, .pop, .pop_entry
  );

  bis_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .WEIGHT_FRACTION_BITS(WEIGHT_FRACTION_BITS)
  ) u_back (
    .clk, .rst, .q_valid(pop_valid), .q_pop(pop), .q_entry(pop_entry),
    .out_valid, .out_ready, .out_red, .out_green, .out_blue,
    .out_column, .out_line, .row_end, .frame_end
  );

endmodule
